// ----- design/bba_pkg.sv -----
`timescale 1ns / 1ps

package bba_pkg;

	// Tree geometry. LEAVES must be a power of two.
	localparam int LEAVES = 256;
	localparam int LEAF_W = $clog2(LEAVES);
	localparam int NODE_W = LEAF_W + 1;
	localparam int DEPTH  = 2 * LEAVES;

	// Usage counters saturate at the top of their range.
	localparam int CNT_W = 9;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam int WIDE_W = ((NODE_W > CNT_W) ? NODE_W : CNT_W) + 1;

	localparam logic [7:0] NODE_FREE    = 8'hFF;
	localparam logic [7:0] NODE_UNAVAIL = 8'h00;

	localparam logic [1:0] MODE_ALLOC   = 2'd0;
	localparam logic [1:0] MODE_FREE    = 2'd1;
	localparam logic [1:0] MODE_PIN     = 2'd2;
	localparam logic [1:0] MODE_RELEASE = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] size_shift;
		logic [7:0] owner;
		logic [7:0] leaf_index;
	} req_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] base_leaf;
		logic [8:0] used_blocks;
		logic [8:0] free_blocks;
	} rsp_t;

	// Command from the request side to the tree sequencer.
	typedef struct packed {
		logic              start;
		logic [1:0]        mode;
		logic [3:0]        shift;
		logic [7:0]        owner;
		logic [LEAF_W-1:0] leaf;
	} cmd_t;

	// Status from the tree sequencer.
	typedef struct packed {
		logic              ready;
		logic              done;
		logic              found;
		logic [LEAF_W-1:0] base;
		logic [NODE_W-1:0] run;
	} sts_t;

	// One write port and one read port on the tree memory.
	typedef struct packed {
		logic              wr_en;
		logic [NODE_W-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic              rd_en;
		logic [NODE_W-1:0] rd_addr;
	} mem_req_t;

endpackage

// ----- design/buddy_block_allocator_core.sv -----
`timescale 1ns / 1ps

// Buddy block allocator over a binary tree of owner bytes, one byte per node.
// Requests arrive on req_valid / req_stall / req_data; a request is taken at a
// clock edge where req_valid is high and req_stall is low. Each request gives
// exactly one response on rsp_valid / rsp_stall / rsp_data, in order.
// The block works on one request at a time. A pin or a release of one leaf
// walks the tree one level per cycle. An alloc scans its tree level at one
// node per cycle and then pins each leaf of the run in turn, so a large alloc
// or free run walks the tree once for each leaf of the run. The tree memory
// has one write port and one read port, and its read is registered.
// After reset the tree memory is swept to unavailable, one entry per cycle;
// req_stall stays high until the sweep is over. The usage counters are
// cleared at once.
// A finished response sits in an output register; while rsp_stall holds it,
// the next request is still accepted and processed, and only its response
// waits for the register to drain.
module buddy_block_allocator_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bba_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bba_pkg::rsp_t rsp_data
);
	import bba_pkg::*;

	cmd_t     cmd;
	sts_t     sts;
	mem_req_t mreq;
	logic [7:0] rd_data;

	// busy_q covers the span from acceptance to the response being loaded.
	logic             busy_q;
	logic             pend_q;
	logic [1:0]       mode_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] pool_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic              accept;
	logic              res_ready;
	logic              load;
	logic [WIDE_W-1:0] used_w;
	logic [WIDE_W-1:0] run_w;
	logic [WIDE_W-1:0] used_sum;
	logic [WIDE_W-1:0] used_diff;
	logic [CNT_W-1:0]  used_add;
	logic [CNT_W-1:0]  used_sub;
	logic [CNT_W-1:0]  pool_inc;
	logic [CNT_W-1:0]  used_nxt;
	logic [CNT_W-1:0]  pool_nxt;
	logic [CNT_W-1:0]  free_nxt;

	assign req_stall = busy_q || !sts.ready;
	assign accept    = req_valid && !req_stall;

	assign cmd.start = accept;
	assign cmd.mode  = req_data.mode;
	assign cmd.shift = req_data.size_shift;
	assign cmd.owner = req_data.owner;
	// Leaf numbers beyond the tree wrap round.
	assign cmd.leaf  = LEAF_W'(req_data.leaf_index);

	bba_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_data (rd_data),
		.mreq    (mreq),
		.sts     (sts)
	);

	bba_tree_ram u_ram (
		.clk     (clk),
		.mreq    (mreq),
		.rd_data (rd_data)
	);

	// Counter updates. An alloc adds its run, a free run subtracts the leaves
	// it actually released (floored at zero), and a release grows the pool.
	assign used_w    = WIDE_W'(used_q);
	assign run_w     = WIDE_W'(sts.run);
	assign used_sum  = used_w + run_w;
	assign used_diff = used_w - run_w;
	assign used_add  = (used_sum > WIDE_W'(CNT_MAX)) ? CNT_MAX : used_sum[CNT_W-1:0];
	assign used_sub  = (used_w > run_w) ? used_diff[CNT_W-1:0] : '0;
	assign pool_inc  = (pool_q == CNT_MAX) ? pool_q : pool_q + CNT_W'(1);

	always_comb begin
		used_nxt = used_q;
		pool_nxt = pool_q;
		unique case (mode_q)
			MODE_ALLOC:   used_nxt = sts.found ? used_add : used_q;
			MODE_FREE:    used_nxt = used_sub;
			MODE_PIN:     used_nxt = used_q;
			MODE_RELEASE: pool_nxt = pool_inc;
		endcase
	end

	assign free_nxt = (pool_nxt > used_nxt) ? (pool_nxt - used_nxt) : '0;

	// The result may be loaded in the cycle the sequencer reports it, or later
	// once the output register has been taken.
	assign res_ready = sts.done || pend_q;
	assign load      = res_ready && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_q      <= 1'b0;
			used_q      <= '0;
			pool_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			pend_q <= res_ready && !load;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				used_q      <= used_nxt;
				pool_q      <= pool_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req_data.mode;
		end
		if (load) begin
			rsp_q.ok          <= sts.found;
			rsp_q.base_leaf   <= 8'(sts.base);
			rsp_q.used_blocks <= used_nxt;
			rsp_q.free_blocks <= free_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// ----- design/bba_tree_ram.sv -----
`timescale 1ns / 1ps

module bba_tree_ram (
	input  logic              clk,
	input  bba_pkg::mem_req_t mreq,
	output logic [7:0]        rd_data
);
	import bba_pkg::*;

	logic [7:0] mem [DEPTH];

	// Read returns the old contents when the same entry is written in that cycle.
	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			mem[mreq.wr_addr] <= mreq.wr_data;
		end
		if (mreq.rd_en) begin
			rd_data <= mem[mreq.rd_addr];
		end
	end

endmodule

// ----- design/bba_seq.sv -----
`timescale 1ns / 1ps

module bba_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  bba_pkg::cmd_t     cmd,
	input  logic [7:0]        rd_data,
	output bba_pkg::mem_req_t mreq,
	output bba_pkg::sts_t     sts
);
	import bba_pkg::*;

	localparam logic [2:0] S_CLEAR    = 3'd0;
	localparam logic [2:0] S_IDLE     = 3'd1;
	localparam logic [2:0] S_SCAN     = 3'd2;
	localparam logic [2:0] S_PIN_WR   = 3'd3;
	localparam logic [2:0] S_PIN_TEST = 3'd4;
	localparam logic [2:0] S_REL_WR   = 3'd5;
	localparam logic [2:0] S_REL_TEST = 3'd6;
	localparam logic [2:0] S_REL_FILL = 3'd7;

	logic [2:0]        state_q;
	logic [NODE_W-1:0] clr_q;
	logic [NODE_W-1:0] node_q;
	logic [NODE_W-1:0] scan_k_q;
	logic [NODE_W-1:0] scan_last_q;
	logic [NODE_W-1:0] cnt_q;
	logic [NODE_W-1:0] rem_q;
	logic [NODE_W-1:0] run_q;
	logic [NODE_W-1:0] chk_k_s1;
	logic              chk_vld_s1;
	logic [LEAF_W-1:0] leaf_q;
	logic [LEAF_W-1:0] base_q;
	logic [7:0]        tag_q;
	logic [7:0]        sib_q;
	logic [3:0]        shift_q;
	logic              is_pin_q;
	logic              issue_q;
	logic              done_q;
	logic              found_q;

	logic [NODE_W-1:0] leaf_node;
	logic [NODE_W-1:0] par_node;
	logic              rd_free;
	logic              hit;
	logic              miss_end;
	logic              fin;
	logic              last_leaf;
	logic [NODE_W-1:0] cmd_cnt;
	logic [NODE_W-1:0] room;
	logic [NODE_W-1:0] pow;
	logic [NODE_W-1:0] free_run;
	logic [NODE_W-1:0] hit_off;
	logic [LEAF_W-1:0] hit_base;
	logic [NODE_W-1:0] alloc_run;

	assign leaf_node = {1'b1, leaf_q};
	assign par_node  = node_q >> 1;
	assign rd_free   = (rd_data == NODE_FREE);
	assign hit       = chk_vld_s1 && rd_free;
	assign miss_end  = chk_vld_s1 && !rd_free && (chk_k_s1 == scan_last_q);
	assign last_leaf = (rem_q == NODE_W'(1));

	assign cmd_cnt  = NODE_W'(LEAVES) >> cmd.shift;
	assign room     = NODE_W'(LEAVES) - {1'b0, cmd.leaf};
	assign pow      = NODE_W'(1) << cmd.shift;
	assign free_run = ((int'(cmd.shift) > LEAF_W) || (pow > room)) ? room : pow;

	assign hit_off   = (chk_k_s1 - cnt_q) << shift_q;
	assign hit_base  = hit_off[LEAF_W-1:0];
	assign alloc_run = NODE_W'(1) << shift_q;

	// A walk for one leaf ends here.
	always_comb begin
		fin = 1'b0;
		unique case (state_q)
			S_PIN_TEST: fin = !rd_free || (par_node == '0);
			S_REL_TEST: fin = (par_node == NODE_W'(1));
			S_REL_FILL: fin = (par_node == NODE_W'(1));
			default:    fin = 1'b0;
		endcase
	end

	always_comb begin
		mreq = '0;
		unique case (state_q)
			S_CLEAR: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_addr = clr_q;
				mreq.wr_data = NODE_UNAVAIL;
			end
			S_SCAN: begin
				mreq.rd_en   = issue_q;
				mreq.rd_addr = scan_k_q;
			end
			S_PIN_WR: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_addr = leaf_node;
				mreq.wr_data = tag_q;
				mreq.rd_en   = 1'b1;
				mreq.rd_addr = leaf_node >> 1;
			end
			S_PIN_TEST: begin
				if (rd_free) begin
					mreq.wr_en   = 1'b1;
					mreq.wr_addr = node_q;
					mreq.wr_data = tag_q;
					mreq.rd_en   = (par_node != '0);
					mreq.rd_addr = par_node;
				end
			end
			S_REL_WR: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_addr = leaf_node;
				mreq.wr_data = NODE_FREE;
				mreq.rd_en   = 1'b1;
				mreq.rd_addr = leaf_node ^ NODE_W'(1);
			end
			S_REL_TEST: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_addr = par_node;
				if (rd_free) begin
					mreq.wr_data = NODE_FREE;
					mreq.rd_en   = (par_node > NODE_W'(1));
					mreq.rd_addr = par_node ^ NODE_W'(1);
				end else begin
					mreq.wr_data = rd_data;
				end
			end
			S_REL_FILL: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_addr = par_node;
				mreq.wr_data = sib_q;
			end
			default: mreq = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			done_q     <= 1'b0;
			issue_q    <= 1'b0;
			chk_vld_s1 <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + NODE_W'(1);
					if (clr_q == NODE_W'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd.start) begin
						tag_q   <= cmd.owner;
						shift_q <= cmd.shift;
						leaf_q  <= cmd.leaf;
						base_q  <= '0;
						found_q <= 1'b1;
						run_q   <= '0;
						unique case (cmd.mode)
							MODE_ALLOC: begin
								cnt_q       <= cmd_cnt;
								scan_k_q    <= cmd_cnt;
								scan_last_q <= (cmd_cnt << 1) - NODE_W'(1);
								issue_q     <= 1'b1;
								chk_vld_s1  <= 1'b0;
								is_pin_q    <= 1'b1;
								if (cmd_cnt == '0) begin
									found_q <= 1'b0;
									done_q  <= 1'b1;
								end else begin
									state_q <= S_SCAN;
								end
							end
							MODE_FREE: begin
								rem_q    <= free_run;
								run_q    <= free_run;
								is_pin_q <= 1'b0;
								state_q  <= S_REL_WR;
							end
							MODE_PIN: begin
								rem_q    <= NODE_W'(1);
								is_pin_q <= 1'b1;
								state_q  <= S_PIN_WR;
							end
							MODE_RELEASE: begin
								rem_q    <= NODE_W'(1);
								is_pin_q <= 1'b0;
								state_q  <= S_REL_WR;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						leaf_q     <= hit_base;
						base_q     <= hit_base;
						rem_q      <= alloc_run;
						run_q      <= alloc_run;
						chk_vld_s1 <= 1'b0;
						state_q    <= S_PIN_WR;
					end else if (miss_end) begin
						found_q    <= 1'b0;
						done_q     <= 1'b1;
						chk_vld_s1 <= 1'b0;
						state_q    <= S_IDLE;
					end else begin
						chk_k_s1   <= scan_k_q;
						chk_vld_s1 <= issue_q;
						if (issue_q) begin
							scan_k_q <= scan_k_q + NODE_W'(1);
							if (scan_k_q == scan_last_q) begin
								issue_q <= 1'b0;
							end
						end
					end
				end
				S_PIN_WR: begin
					node_q  <= leaf_node >> 1;
					state_q <= S_PIN_TEST;
				end
				S_PIN_TEST: begin
					node_q <= par_node;
				end
				S_REL_WR: begin
					node_q  <= leaf_node;
					state_q <= S_REL_TEST;
				end
				S_REL_TEST: begin
					node_q <= par_node;
					if (!rd_free) begin
						sib_q   <= rd_data;
						state_q <= S_REL_FILL;
					end
				end
				S_REL_FILL: begin
					node_q <= par_node;
				end
			endcase

			if (fin) begin
				if (last_leaf) begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end else begin
					rem_q   <= rem_q - NODE_W'(1);
					leaf_q  <= leaf_q + LEAF_W'(1);
					state_q <= is_pin_q ? S_PIN_WR : S_REL_WR;
				end
			end
		end
	end

	assign sts.ready = (state_q == S_IDLE);
	assign sts.done  = done_q;
	assign sts.found = found_q;
	assign sts.base  = base_q;
	assign sts.run   = run_q;

endmodule

// ----- design/bba_checker.sv -----
`timescale 1ns / 1ps

module bba_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input bba_pkg::req_t req_data,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input bba_pkg::rsp_t rsp_data
);
	import bba_pkg::*;

	// A held response keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	// Only one request is in flight at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request side open straight after a request");

	// A new response only comes from a request that was in progress.
	a_rsp_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response appeared with no request in progress");

	// A failed alloc reports no base leaf.
	a_fail_base: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.ok |-> rsp_data.base_leaf == 8'd0)
		else $error("failed request reports a base leaf");

endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_data  (req_data),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_data  (rsp_data)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

	import bba_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;

	buddy_block_allocator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Shadow copy of the allocator state, advanced once per accepted request.
	logic [7:0]  tree_m [0:DEPTH-1];
	int unsigned used_m;
	int unsigned pool_m;

	req_t        pending [$];
	rsp_t        ledger_q [$];
	rsp_t        want;
	int unsigned n_sent = 0;
	int unsigned n_rcvd = 0;
	int unsigned n_grant = 0;
	int unsigned n_refuse = 0;
	int unsigned err_count = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned long_hold = 0;
	bit          hold_done = 1'b0;
	bit          calm = 1'b0;
	longint      cost_budget = 0;
	longint      cycle_count = 0;
	longint      cycle_limit;

	function automatic void pin_node(input int unsigned leaf, input logic [7:0] tag);
		int unsigned k;
		k = LEAVES + leaf;
		tree_m[k] = tag;
		k = k >> 1;
		while (k != 0 && tree_m[k] == NODE_FREE) begin
			tree_m[k] = tag;
			k = k >> 1;
		end
	endfunction

	function automatic void free_node(input int unsigned leaf);
		int unsigned k;
		logic [7:0]  sib;
		k = LEAVES + leaf;
		sib = NODE_UNAVAIL;
		tree_m[k] = NODE_FREE;
		while (k > 1) begin
			sib = tree_m[k ^ 1];
			if (sib != NODE_FREE)
				break;
			k = k >> 1;
			tree_m[k] = NODE_FREE;
		end
		while (k > 1) begin
			k = k >> 1;
			tree_m[k] = sib;
		end
	endfunction

	function automatic rsp_t ledger_apply(input req_t r);
		rsp_t        o;
		int unsigned cnt;
		int unsigned run;
		int unsigned k;
		int unsigned base;
		int unsigned lf;
		int unsigned avail;
		logic        ok;
		lf = r.leaf_index % LEAVES;
		ok = 1'b1;
		base = 0;
		case (r.mode)
			MODE_ALLOC: begin
				cnt = LEAVES >> r.size_shift;
				ok = 1'b0;
				for (k = cnt; k < 2 * cnt && !ok; k++) begin
					if (tree_m[k] == NODE_FREE) begin
						run = 1 << r.size_shift;
						base = (k - cnt) << r.size_shift;
						for (int unsigned i = 0; i < run; i++)
							pin_node(base + i, r.owner);
						used_m = (used_m + run > CNT_MAX) ? CNT_MAX : used_m + run;
						ok = 1'b1;
					end
				end
				if (ok)
					n_grant++;
				else
					n_refuse++;
			end
			MODE_FREE: begin
				run = 1 << r.size_shift;
				if (run > LEAVES - lf)
					run = LEAVES - lf;
				for (int unsigned i = 0; i < run; i++)
					free_node(lf + i);
				used_m = (used_m > run) ? used_m - run : 0;
			end
			MODE_PIN: begin
				pin_node(lf, r.owner);
			end
			default: begin
				pool_m = (pool_m + 1 > CNT_MAX) ? CNT_MAX : pool_m + 1;
				free_node(lf);
			end
		endcase
		avail = (pool_m > used_m) ? pool_m - used_m : 0;
		o.ok = ok;
		o.base_leaf = base[7:0];
		o.used_blocks = used_m[8:0];
		o.free_blocks = avail[8:0];
		return o;
	endfunction

	// Queues one request and adds a generous estimate of its cost to the budget.
	function automatic void queue_item(input logic [1:0] m, input int unsigned s,
			input int unsigned o, input int unsigned l);
		req_t        r;
		longint      run;
		r.mode = m;
		r.size_shift = s[3:0];
		r.owner = o[7:0];
		r.leaf_index = l[7:0];
		pending.push_back(r);
		run = (r.size_shift > LEAF_W) ? LEAVES : (1 << r.size_shift);
		if (m == MODE_ALLOC)
			cost_budget += (LEAVES >> r.size_shift) + run * 2 * (LEAF_W + 4);
		else if (m == MODE_FREE)
			cost_budget += run * 2 * (LEAF_W + 4);
		else
			cost_budget += 2 * (LEAF_W + 4);
		cost_budget += 60;
	endfunction

	function automatic int unsigned pick_shift();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(0, 15);
	endfunction

	function automatic int unsigned pick_owner();
		int unsigned c;
		c = $urandom_range(0, 15);
		if (c == 0)
			return NODE_FREE;
		if (c == 1)
			return NODE_UNAVAIL;
		return $urandom_range(0, 255);
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Request driver: the payload holds while stalled, gaps only between requests.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			calm <= (pending.size() < 120);
			if (req_valid && !req_stall) begin
				ledger_q.push_back(ledger_apply(req_data));
				n_sent++;
			end
			if (!(req_valid && req_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending.size() == 0) begin
					req_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 11) == 0) begin
					gap_left = $urandom_range(1, 17) - 1;
					req_valid <= 1'b0;
				end else begin
					req_data <= pending.pop_front();
					req_valid <= 1'b1;
				end
			end
		end
	end

	// Response stall: short random bursts, plus one long hold-off to back the block up.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (long_hold > 0) begin
			long_hold--;
			rsp_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else if (!calm && !hold_done && n_rcvd >= 300) begin
			hold_done = 1'b1;
			long_hold = 599;
			rsp_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			stall_left = $urandom_range(1, 17) - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Response checker.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			n_rcvd <= n_rcvd + 1;
			if (ledger_q.size() == 0) begin
				$error("response arrived with no request outstanding");
				err_count++;
			end else begin
				want = ledger_q.pop_front();
				if (rsp_data.ok !== want.ok) begin
					$error("ok: expected %0d, got %0d", want.ok, rsp_data.ok);
					err_count++;
				end
				if (rsp_data.base_leaf !== want.base_leaf) begin
					$error("base_leaf: expected %0d, got %0d", want.base_leaf,
						rsp_data.base_leaf);
					err_count++;
				end
				if (rsp_data.used_blocks !== want.used_blocks) begin
					$error("used_blocks: expected %0d, got %0d", want.used_blocks,
						rsp_data.used_blocks);
					err_count++;
				end
				if (rsp_data.free_blocks !== want.free_blocks) begin
					$error("free_blocks: expected %0d, got %0d", want.free_blocks,
						rsp_data.free_blocks);
					err_count++;
				end
			end
		end
	end

	initial begin
		int unsigned n_rand;
		int unsigned pick;
		int unsigned s;
		int unsigned b;
		foreach (tree_m[i])
			tree_m[i] = NODE_UNAVAIL;
		used_m = 0;
		pool_m = 0;

		// Directed part: empty tree, out-of-range levels, owner tags that read as
		// free or unavailable, and a free run past the end.
		queue_item(MODE_ALLOC, 0, 8'h01, 0);
		queue_item(MODE_FREE, 0, 0, 0);
		queue_item(MODE_PIN, 0, 8'h12, 3);
		queue_item(MODE_RELEASE, 0, 0, 0);
		queue_item(MODE_RELEASE, 0, 0, 1);
		queue_item(MODE_ALLOC, 1, 8'h01, 0);
		queue_item(MODE_ALLOC, 0, 8'h02, 0);
		queue_item(MODE_FREE, 1, 0, 0);
		queue_item(MODE_ALLOC, 0, NODE_FREE, 0);
		queue_item(MODE_ALLOC, 0, NODE_UNAVAIL, 0);
		queue_item(MODE_RELEASE, 15, 8'hFF, 255);
		queue_item(MODE_RELEASE, 0, 0, 254);
		queue_item(MODE_PIN, 0, 8'hAA, 255);
		queue_item(MODE_PIN, 0, NODE_FREE, 254);
		queue_item(MODE_FREE, 8, 0, 255);
		queue_item(MODE_ALLOC, 9, 8'h33, 0);
		queue_item(MODE_ALLOC, 15, 8'h34, 0);
		queue_item(MODE_ALLOC, 8, 8'h35, 0);
		queue_item(MODE_FREE, 15, 0, 0);
		queue_item(MODE_ALLOC, 8, NODE_FREE, 0);
		queue_item(MODE_ALLOC, 8, NODE_FREE, 0);
		queue_item(MODE_FREE, 8, 0, 0);
		queue_item(MODE_FREE, 8, 0, 128);
		queue_item(MODE_ALLOC, 8, 8'h5A, 0);
		queue_item(MODE_FREE, 8, 0, 0);

		// Random part: mostly runs of releases that build free subtrees, then
		// allocs and aligned frees that carve them up, with some noise mixed in.
		n_rand = 0;
		while (n_rand < 1170) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				s = $urandom_range(0, 4);
				b = ($urandom_range(0, 255) >> s) << s;
				for (int unsigned i = 0; i < (1 << s); i++)
					queue_item(MODE_RELEASE, $urandom_range(0, 15), $urandom_range(0, 255),
						b + i);
				n_rand += 1 << s;
			end else if (pick < 50) begin
				queue_item(MODE_ALLOC, pick_shift(), pick_owner(), $urandom_range(0, 255));
				n_rand++;
			end else if (pick < 70) begin
				s = pick_shift();
				b = $urandom_range(0, 255);
				if ($urandom_range(0, 3) != 0 && s <= LEAF_W)
					b = (b >> s) << s;
				queue_item(MODE_FREE, s, $urandom_range(0, 255), b);
				n_rand++;
			end else if (pick < 82) begin
				queue_item(MODE_PIN, $urandom_range(0, 15), pick_owner(),
					$urandom_range(0, 255));
				n_rand++;
			end else begin
				queue_item($urandom_range(0, 3), $urandom_range(0, 15), $urandom_range(0, 255),
					$urandom_range(0, 255));
				n_rand++;
			end
		end
		cycle_limit = 4 * cost_budget + 4 * DEPTH + 20000;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while ((pending.size() > 0 || req_valid || ledger_q.size() > 0) &&
				cycle_count < cycle_limit)
			@(posedge clk);

		if (cycle_count >= cycle_limit) begin
			$display("Timed out after %0d cycles with %0d responses outstanding",
				cycle_count, ledger_q.size());
			$display("Some tests failed");
		end else begin
			repeat (200) @(posedge clk);
			$display("Sent %0d requests and checked %0d responses in %0d cycles.",
				n_sent, n_rcvd, cycle_count);
			$display("Allocations granted: %0d, refused: %0d; mismatches: %0d.",
				n_grant, n_refuse, err_count);
			if (err_count == 0) begin
				$display("All tests passed");
			end else begin
				$display("Some tests failed");
			end
		end
		$finish;
	end

endmodule
